// File: design/clsr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clsr_pkg
// Constants, microcode types and the control store of the combined
// congruential generator with shuffle table.
// ----------------------------------------------------------------------------
package clsr_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 32;
	localparam int unsigned WARMUP          = 8;

	localparam logic [30:0] MOD1        = 31'd2147483563;
	localparam logic [30:0] MOD2        = 31'd2147483399;
	localparam logic [15:0] MUL1        = 16'd40014;
	localparam logic [15:0] MUL2        = 16'd40692;
	// 2^31 mod m for each modulus, used to fold the high product bits
	localparam logic [7:0]  FOLD1       = 8'd85;
	localparam logic [7:0]  FOLD2       = 8'd249;
	localparam logic [30:0] SECOND_INIT = 31'd123456789;

	// control store addresses
	typedef enum logic [3:0] {
		U_IDLE,
		U_SEED_LOAD,
		U_SEED_MUL,
		U_SEED_RED,
		U_DRAW_MUL1,
		U_DRAW_RED1,
		U_DRAW_MUL2,
		U_DRAW_RED2,
		U_READ,
		U_DRAW
	} upc_t;

	typedef enum logic [3:0] {
		A_NONE,
		A_LOAD,
		A_MUL1,
		A_MUL2,
		A_RED_FILL,
		A_RED1,
		A_RED2,
		A_READ,
		A_DRAW
	} act_t;

	typedef enum logic [2:0] {
		J_NEXT,
		J_ALWAYS,
		J_IDLE,
		J_LOOP_CNT,
		J_OUT
	} jump_t;

	typedef struct packed {
		act_t  act;
		jump_t jump;
		upc_t  target;
	} uword_t;

	function automatic uword_t ucode(input upc_t pc);
		uword_t w;
		case (pc)
			U_IDLE:      w = '{act: A_NONE,     jump: J_IDLE,     target: U_DRAW_MUL1};
			U_SEED_LOAD: w = '{act: A_LOAD,     jump: J_NEXT,     target: U_IDLE};
			U_SEED_MUL:  w = '{act: A_MUL1,     jump: J_NEXT,     target: U_IDLE};
			U_SEED_RED:  w = '{act: A_RED_FILL, jump: J_LOOP_CNT, target: U_SEED_MUL};
			U_DRAW_MUL1: w = '{act: A_MUL1,     jump: J_NEXT,     target: U_IDLE};
			U_DRAW_RED1: w = '{act: A_RED1,     jump: J_NEXT,     target: U_IDLE};
			U_DRAW_MUL2: w = '{act: A_MUL2,     jump: J_NEXT,     target: U_IDLE};
			U_DRAW_RED2: w = '{act: A_RED2,     jump: J_NEXT,     target: U_IDLE};
			U_READ:      w = '{act: A_READ,     jump: J_NEXT,     target: U_IDLE};
			U_DRAW:      w = '{act: A_DRAW,     jump: J_OUT,      target: U_IDLE};
			default:     w = '{act: A_NONE,     jump: J_ALWAYS,   target: U_IDLE};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// File: design/combined_lcg_shuffle_rng_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng_unit
// Combined two-modulus congruential generator behind a shuffle table,
// run by a small microcoded sequencer over one shared multiplier.
// ----------------------------------------------------------------------------
// Each request transfer returns one deviate in 1..2147483562 (divide by
// 2147483563 for a value in (0,1)). A normal draw runs the steps
// DRAW_MUL1, DRAW_RED1, DRAW_MUL2, DRAW_RED2, READ and DRAW before the next
// request is taken: the two generator steps share one 31x16 multiplier
// followed by a fold and reduce step, the table index comes from a row of
// compares against the bucket boundaries, and the table is read and written
// through one write port and one read port. A request with reseed set, and
// the first request after reset, first loads both generators from the seed
// register (zero acts as one) and then runs the warm-up and table fill
// steps. A result waiting in the output register does not stop the next
// request from being taken; the block holds its final step until the
// output register is free.

module combined_lcg_shuffle_rng_unit #(
	parameter int unsigned TABLE_DEPTH = clsr_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        seed_we,
	input  wire logic [30:0] seed,
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire logic        reseed,
	output logic             rsp_valid,
	input  wire logic        rsp_ready,
	output logic [30:0]      deviate
);

	localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + clsr_pkg::WARMUP);
	localparam logic [30:0] SPAN =
		31'(64'd1 + (64'(clsr_pkg::MOD1) - 64'd1) / 64'(TABLE_DEPTH));
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(TABLE_DEPTH + clsr_pkg::WARMUP - 1);
	localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(TABLE_DEPTH);

	clsr_pkg::upc_t   upc_q;
	clsr_pkg::upc_t   upc_d;
	clsr_pkg::uword_t uw;

	logic [30:0]      seed_q;
	logic [30:0]      first_q;
	logic [30:0]      second_q;
	logic [30:0]      last_q;
	logic             seeded_q;
	logic             rsp_valid_q;
	logic [CNT_W-1:0] cnt_q;

	logic [46:0]      prod_q;
	logic [IDX_W-1:0] quot_q;
	logic [IDX_W-1:0] idx_q;
	logic [30:0]      rd_q;
	logic [30:0]      out_q;

	logic [30:0]      mem [TABLE_DEPTH];

	logic             in_xfer;
	logic             slot_free;
	logic             draw_go;
	logic [30:0]      mul_x;
	logic [15:0]      mul_a;
	logic [46:0]      prod_d;
	logic             use_g2;
	logic [31:0]      fold_sum;
	logic [31:0]      fold_mod;
	logic [30:0]      red;
	logic [TABLE_DEPTH:0] span_ge;
	logic [IDX_W-1:0] quot_d;
	logic [IDX_W-1:0] sel_idx;
	logic [32:0]      diff;
	logic [30:0]      y;
	logic [30:0]      seed_eff;
	logic             fill_we;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [30:0]      mem_wdata;

	assign uw        = clsr_pkg::ucode(upc_q);
	assign req_ready = (upc_q == clsr_pkg::U_IDLE);
	assign in_xfer   = req_valid & req_ready;
	assign slot_free = ~rsp_valid_q | rsp_ready;
	assign draw_go   = (uw.act == clsr_pkg::A_DRAW) & slot_free;
	assign rsp_valid = rsp_valid_q;
	assign deviate   = out_q;

	// shared multiplier, registered before the fold
	assign mul_x  = (uw.act == clsr_pkg::A_MUL2) ? second_q : first_q;
	assign mul_a  = (uw.act == clsr_pkg::A_MUL2) ? clsr_pkg::MUL2 : clsr_pkg::MUL1;
	assign prod_d = 47'(mul_x) * 47'(mul_a);

	// a*x mod m: high bits times (2^31 mod m) plus low bits, then one subtract
	assign use_g2   = (uw.act == clsr_pkg::A_RED2);
	assign fold_sum = 32'(prod_q[30:0])
		+ 32'(prod_q[46:31]) * 32'(use_g2 ? clsr_pkg::FOLD2 : clsr_pkg::FOLD1);
	assign fold_mod = 32'(use_g2 ? clsr_pkg::MOD2 : clsr_pkg::MOD1);
	assign red      = (fold_sum >= fold_mod) ? 31'(fold_sum - fold_mod) : fold_sum[30:0];

	// bucket of the last output: compare against every bucket boundary
	always_comb begin
		span_ge = '0;
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			span_ge[k] = (last_q >= 31'(64'(k) * 64'(SPAN)));
		end
	end

	// the boundaries rise, so the last passing compare names the bucket
	always_comb begin
		quot_d = '0;
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			if (span_ge[k] & ~span_ge[k+1]) begin
				quot_d = quot_d | IDX_W'(k);
			end
		end
	end

	assign sel_idx = (quot_q > LAST_IDX) ? LAST_IDX : quot_q;

	// shuffled entry minus second generator, wrapped into 1..m1-1
	assign diff = {2'b00, rd_q} - {2'b00, second_q};
	assign y    = (diff[32] | (diff == 33'd0))
		? 31'(diff + 33'(clsr_pkg::MOD1 - 31'd1)) : diff[30:0];

	assign seed_eff = (seed_q == 31'd0) ? 31'd1 : seed_q;

	assign fill_we   = (uw.act == clsr_pkg::A_RED_FILL) & (cnt_q < CNT_DEPTH);
	assign mem_we    = fill_we | draw_go;
	assign mem_waddr = fill_we ? cnt_q[IDX_W-1:0] : idx_q;
	assign mem_wdata = fill_we ? red : first_q;

	always_comb begin
		case (uw.jump)
			clsr_pkg::J_NEXT: begin
				upc_d = clsr_pkg::upc_t'(upc_q + 4'd1);
			end
			clsr_pkg::J_ALWAYS: begin
				upc_d = uw.target;
			end
			clsr_pkg::J_IDLE: begin
				if (!in_xfer) begin
					upc_d = upc_q;
				end else if (reseed | ~seeded_q) begin
					upc_d = clsr_pkg::upc_t'(upc_q + 4'd1);
				end else begin
					upc_d = uw.target;
				end
			end
			clsr_pkg::J_LOOP_CNT: begin
				upc_d = (cnt_q != '0) ? uw.target : clsr_pkg::upc_t'(upc_q + 4'd1);
			end
			clsr_pkg::J_OUT: begin
				upc_d = slot_free ? uw.target : upc_q;
			end
			default: begin
				upc_d = clsr_pkg::U_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q       <= clsr_pkg::U_IDLE;
			seed_q      <= 31'd1;
			first_q     <= 31'd1;
			second_q    <= clsr_pkg::SECOND_INIT;
			last_q      <= '0;
			seeded_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			upc_q <= upc_d;
			if (seed_we) begin
				seed_q <= seed;
			end
			case (uw.act)
				clsr_pkg::A_LOAD: begin
					first_q  <= seed_eff;
					second_q <= seed_eff;
					cnt_q    <= CNT_INIT;
				end
				clsr_pkg::A_RED_FILL: begin
					first_q <= red;
					cnt_q   <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						last_q   <= red;
						seeded_q <= 1'b1;
					end
				end
				clsr_pkg::A_RED1: begin
					first_q <= red;
				end
				clsr_pkg::A_RED2: begin
					second_q <= red;
				end
				clsr_pkg::A_DRAW: begin
					if (slot_free) begin
						last_q <= y;
					end
				end
				default: begin
				end
			endcase
			if (draw_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath payload
	always_ff @(posedge clk) begin
		case (uw.act)
			clsr_pkg::A_MUL1, clsr_pkg::A_MUL2: begin
				prod_q <= prod_d;
			end
			clsr_pkg::A_RED1: begin
				quot_q <= quot_d;
			end
			clsr_pkg::A_READ: begin
				idx_q <= sel_idx;
			end
			default: begin
			end
		endcase
		if (draw_go) begin
			out_q <= y;
		end
	end

	// shuffle table, one write and one registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (uw.act == clsr_pkg::A_READ) begin
			rd_q <= mem[sel_idx];
		end
	end

	a_deviate_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (deviate != 31'd0) && (deviate < clsr_pkg::MOD1))
		else $error("deviate out of range");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while sequencer busy");

	a_result_needs_seed: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> seeded_q && $past(upc_q) == clsr_pkg::U_DRAW)
		else $error("result produced outside draw step or before seeding");

	a_fill_in_seed: assert property (@(posedge clk) disable iff (!arst_n)
		fill_we |-> !seeded_q || $past(seeded_q))
		else $error("table fill outside seeding");

endmodule
`default_nettype wire
